[rtl/edbp_pkg.sv]
// edbp_pkg: widths, constants and types shared by the error diffusion bit packer
// no dependencies; compiled first

package edbp_pkg;

    localparam int MAX_COLUMNS   = 1440;
    localparam int NUM_CHANNELS  = 3;
    localparam int CERR_DEPTH    = MAX_COLUMNS * NUM_CHANNELS;
    localparam int CERR_AW       = $clog2(CERR_DEPTH);
    localparam int VALUE_W       = 8;
    localparam int COL_W         = 11;
    localparam int CH_W          = 2;
    localparam int ERR_W         = 16;
    localparam int SUM_W         = 18;
    localparam int MAG_W         = 17;
    localparam int DIV3_MULT_W   = 16;
    localparam int DIV3_SHIFT    = 17;
    localparam int PROD_W        = MAG_W + DIV3_MULT_W;
    localparam int IDX_CALC_W    = 16;

    localparam logic [DIV3_MULT_W-1:0] DIV3_MULT     = 16'd43691;
    localparam logic signed [SUM_W-1:0] ON_THRESHOLD = 18'sd128;
    localparam logic signed [SUM_W-1:0] ON_OFFSET    = 18'sd256;
    localparam logic [2:0]             LOW_BITS_MASK = 3'd7;
    localparam logic [CH_W-1:0]        CH_UNUSED     = 2'd3;

    localparam logic signed [ERR_W-1:0] ERR_MAX = 16'sh7FFF;
    localparam logic signed [ERR_W-1:0] ERR_MIN = 16'sh8000;

    typedef logic signed [ERR_W-1:0] err_t;

endpackage

[rtl/edbp_ifs.sv]
// edbp_ifs: valid/ready channels for pixel components in and packed bytes out
// depends on edbp_pkg

interface edbp_pix_if;
    import edbp_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] pixel_value;
    logic [COL_W-1:0]   column;
    logic [CH_W-1:0]    channel;
    logic               row_end;

    modport source (output valid, pixel_value, column, channel, row_end, input ready);
    modport sink   (input valid, pixel_value, column, channel, row_end, output ready);
endinterface

interface edbp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       last_of_row;

    modport source (output valid, packed_byte, last_of_row, input ready);
    modport sink   (input valid, packed_byte, last_of_row, output ready);
endinterface

[rtl/edbp_ram.sv]
// edbp_ram: generic single write port, single read port ram with registered read
// no dependencies

module edbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/error_diffusion_bit_packer_top.sv]
// error_diffusion_bit_packer_top: dithers colour components to bits and packs them into bytes
// depends on edbp_pkg, edbp_ifs and edbp_ram
//
// pix takes one colour component per item with its column, channel and row_end flag;
// pbyte gives one packed byte whenever an item's column ends in binary 111 or row_end is set.
// channel 3 items are taken and dropped without effect.
// throughput: one item per clock once the column error store is cleared, bar output stalls.
// byte path: the closing item sits in the input stage with its column error read, then
// loads the output register, which drives pbyte.
// the column error store is one ram of MAX_COLUMNS*3 words; its read and write port let a
// read and the write-back of an earlier item share each clock, with forwarding of the two
// write-backs still in flight.
// reset: running errors and the bit accumulator clear at once; the column error store is
// then swept to zero one word per clock, all MAX_COLUMNS*3 (4320) words, with pix.ready low.
// stall: the output register holds a byte until pbyte.ready; the input keeps taking items
// until an item that closes a byte finds that register still full, then pix.ready drops.

module error_diffusion_bit_packer_top (
    input  logic clk,
    input  logic rst_n,
    edbp_pix_if.sink    pix,
    edbp_byte_if.source pbyte
);
    import edbp_pkg::*;

    // clear sweep
    logic               clearing_reg;
    logic [CERR_AW-1:0] clr_addr_reg;

    // input stage
    logic               s0_valid_reg;
    logic [VALUE_W-1:0] s0_value_reg;
    logic [CH_W-1:0]    s0_ch_reg;
    logic               s0_in_range_reg;
    logic [CERR_AW-1:0] s0_idx_reg;
    logic               s0_low7_reg;
    logic               s0_last_reg;

    // write-back stages
    logic               s1_valid_reg;
    logic [CERR_AW-1:0] s1_idx_reg;
    err_t               s1_run_reg;
    err_t               s1_prev_reg;
    logic               s2_valid_reg;
    logic [CERR_AW-1:0] s2_idx_reg;
    err_t               s2_data_reg;

    err_t               running_reg [NUM_CHANNELS];
    logic [7:0]         acc_reg;

    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;

    logic                  adv;
    logic                  accept;
    logic                  in_range;
    logic [IDX_CALC_W-1:0] idx_full;
    logic [CERR_AW-1:0]    idx;
    logic                  re;
    err_t                  ram_rdata;
    logic                  ram_we;
    logic [CERR_AW-1:0]    ram_waddr;
    err_t                  ram_wdata;

    logic signed [ERR_W:0] s1_sum;
    err_t                  s1_wdata;
    err_t                  cerr;
    err_t                  prev;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] adj;
    logic                  on;
    logic                  neg;
    logic [MAG_W-1:0]      mag;
    logic [PROD_W-1:0]     prod;
    logic [ERR_W-1:0]      quo;
    err_t                  run_new;
    logic                  emit;
    logic [7:0]            acc_shift;

    // column error address
    assign in_range = {1'b0, pix.column} < (COL_W + 1)'(MAX_COLUMNS);
    assign idx_full = IDX_CALC_W'(pix.column) + IDX_CALC_W'({pix.column, 1'b0})
                    + IDX_CALC_W'(pix.channel);
    assign idx      = idx_full[CERR_AW-1:0];

    assign emit = s0_low7_reg || s0_last_reg;
    assign adv  = !s0_valid_reg || !emit || !out_valid_reg || pbyte.ready;

    assign pix.ready = adv && !clearing_reg;
    assign accept    = pix.valid && pix.ready;
    assign re        = accept && (pix.channel != CH_UNUSED) && in_range;

    // write-back value of the item one stage ahead
    assign s1_sum   = (ERR_W + 1)'(s1_run_reg) + (ERR_W + 1)'(s1_prev_reg);
    assign s1_wdata = (s1_sum > (ERR_W + 1)'(ERR_MAX)) ? ERR_MAX :
                      (s1_sum < (ERR_W + 1)'(ERR_MIN)) ? ERR_MIN : s1_sum[ERR_W-1:0];

    assign ram_we    = clearing_reg || (s1_valid_reg && adv);
    assign ram_waddr = clearing_reg ? clr_addr_reg : s1_idx_reg;
    assign ram_wdata = clearing_reg ? err_t'(0) : s1_wdata;

    edbp_ram #(
        .WIDTH(ERR_W),
        .DEPTH(CERR_DEPTH)
    ) u_cerr_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (re),
        .raddr(idx),
        .rdata(ram_rdata)
    );

    // dither step
    always_comb
    begin
        if (!s0_in_range_reg)
        begin
            cerr = '0;
        end
        else if (s1_valid_reg && (s1_idx_reg == s0_idx_reg))
        begin
            cerr = s1_wdata;
        end
        else if (s2_valid_reg && (s2_idx_reg == s0_idx_reg))
        begin
            cerr = s2_data_reg;
        end
        else
        begin
            cerr = ram_rdata;
        end

        prev = running_reg[s0_ch_reg];
        sum  = SUM_W'(prev) + SUM_W'(signed'({1'b0, s0_value_reg})) + SUM_W'(cerr);
        on   = sum > ON_THRESHOLD;
        adj  = on ? (sum - ON_OFFSET) : sum;
        neg  = adj[SUM_W-1];
        mag  = neg ? MAG_W'(-adj) : MAG_W'(adj);
        prod = PROD_W'(mag) * PROD_W'(DIV3_MULT);
        quo  = prod[DIV3_SHIFT +: ERR_W];
        run_new   = neg ? err_t'(-quo) : err_t'(quo);
        acc_shift = {acc_reg[6:0], on};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == CERR_AW'(CERR_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                running_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            s0_valid_reg <= accept && (pix.channel != CH_UNUSED);
            s1_valid_reg <= s0_valid_reg && s0_in_range_reg;
            s2_valid_reg <= s1_valid_reg;
            if (s0_valid_reg)
            begin
                running_reg[s0_ch_reg] <= run_new;
                acc_reg <= emit ? 8'd0 : acc_shift;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_value_reg    <= pix.pixel_value;
            s0_ch_reg       <= pix.channel;
            s0_in_range_reg <= in_range;
            s0_idx_reg      <= idx;
            s0_low7_reg     <= (pix.column[2:0] == LOW_BITS_MASK);
            s0_last_reg     <= pix.row_end;
            s1_idx_reg      <= s0_idx_reg;
            s1_run_reg      <= run_new;
            s1_prev_reg     <= prev;
            s2_idx_reg      <= s1_idx_reg;
            s2_data_reg     <= s1_wdata;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s0_valid_reg && emit && adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pbyte.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_valid_reg && emit && adv)
        begin
            out_byte_reg <= acc_shift;
            out_last_reg <= s0_last_reg;
        end
    end

    assign pbyte.valid       = out_valid_reg;
    assign pbyte.packed_byte = out_byte_reg;
    assign pbyte.last_of_row = out_last_reg;

endmodule

[rtl/edbp_checker.sv]
// edbp_port_checker: port level checks for error_diffusion_bit_packer_top
// depends on error_diffusion_bit_packer_top; attached by the bind at the end of this file

module edbp_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] packed_byte,
    input logic       last_of_row
);

    // a stalled byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(packed_byte) && $stable(last_of_row))
        else $error("stalled output byte changed");

    // store sweep keeps input closed right after reset
    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !in_ready)
        else $error("input ready during column error sweep");

    // once open, input closes only behind a stalled output
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_ready) && !in_ready |-> out_valid && !out_ready)
        else $error("input ready dropped without output stall");

    // no byte right after reset
    a_no_out_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid)
        else $error("output byte right after reset");

endmodule

bind error_diffusion_bit_packer_top edbp_port_checker u_edbp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pix.valid),
    .in_ready   (pix.ready),
    .out_valid  (pbyte.valid),
    .out_ready  (pbyte.ready),
    .packed_byte(pbyte.packed_byte),
    .last_of_row(pbyte.last_of_row)
);

[test/edbp_checker.sv]
// edbp_checker: dithers accepted pixel items in its own copy of the error state,
// keeps the packed bytes they should produce and compares them with the byte channel
// depends on edbp_pkg and edbp_ifs

module edbp_checker
    import edbp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    edbp_pix_if  pix,
    edbp_byte_if pbyte,
    output int   mismatch_count,
    output int   bytes_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIFFUSE_DIV  = 3;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] bits;
        logic       last;
    } packed_out_t;

    err_t        chan_err [NUM_CHANNELS];
    err_t        col_err [CERR_DEPTH];
    logic [7:0]  bit_acc;
    packed_out_t expected_bytes [$];
    int          fails;

    function automatic err_t clamp_err(int v);
        if (v > int'(ERR_MAX))
            return ERR_MAX;
        if (v < int'(ERR_MIN))
            return ERR_MIN;
        return err_t'(v);
    endfunction

    function automatic void dither_component(logic [VALUE_W-1:0] value,
                                             logic [COL_W-1:0] col,
                                             logic [CH_W-1:0] ch,
                                             logic last);
        int   idx;
        int   prev;
        int   sum;
        int   cerr;
        logic in_range;
        logic on;
        idx  = 0;
        cerr = 0;
        if (ch == CH_UNUSED)
            return;
        in_range = (int'(col) < MAX_COLUMNS);
        if (in_range)
        begin
            idx  = int'(col) * NUM_CHANNELS + int'(ch);
            cerr = col_err[idx];
        end
        prev = chan_err[ch];
        sum  = prev + int'(value) + cerr;
        on   = (sum > ON_THRESHOLD);
        if (on)
            sum = sum - ON_OFFSET;
        sum = sum / DIFFUSE_DIV;
        chan_err[ch] = clamp_err(sum);
        if (in_range)
            col_err[idx] = clamp_err(int'(chan_err[ch]) + prev);
        bit_acc = {bit_acc[6:0], on};
        if (col[2:0] == LOW_BITS_MASK || last)
        begin
            expected_bytes.push_back('{bits: bit_acc, last: last});
            bit_acc = '0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        packed_out_t want;
        if (!rst_n)
        begin
            foreach (chan_err[i])
                chan_err[i] = '0;
            foreach (col_err[i])
                col_err[i] = '0;
            bit_acc = '0;
            expected_bytes.delete();
            fails = 0;
            mismatch_count    <= 0;
            bytes_outstanding <= 0;
        end
        else
        begin
            if (pbyte.valid && pbyte.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("%0t: byte %02h last %0b arrived with nothing expected",
                                 $realtime, pbyte.packed_byte, pbyte.last_of_row);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (want.bits !== pbyte.packed_byte || want.last !== pbyte.last_of_row)
                    begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                            $display("%0t: expected byte %02h last %0b, got byte %02h last %0b",
                                     $realtime, want.bits, want.last,
                                     pbyte.packed_byte, pbyte.last_of_row);
                    end
                end
            end
            if (pix.valid && pix.ready)
                dither_component(pix.pixel_value, pix.column, pix.channel, pix.row_end);
            mismatch_count    <= fails;
            bytes_outstanding <= expected_bytes.size();
        end
    end

endmodule

[test/testbench.sv]
// testbench: drives pixel items into error_diffusion_bit_packer_top, stalls the byte side
// at random and gives the verdict from the counts of edbp_checker
// depends on edbp_pkg, edbp_ifs, edbp_checker and the block's rtl

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import edbp_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int ITEM_TARGET    = 1100;
    localparam int IDLE_PCT       = 26;
    localparam int STEADY_FROM    = 400;
    localparam int STEADY_TO      = 600;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_ROW_LEN    = 24;

    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

    logic clk = 1'b0;
    logic rst_n;
    logic steady;
    int   items_sent = 0;
    int   idle_cycles = 0;
    int   mismatch_count;
    int   bytes_outstanding;

    edbp_pix_if  pix ();
    edbp_byte_if pbyte ();

    error_diffusion_bit_packer_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .pbyte (pbyte)
    );

    edbp_checker byte_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .pix               (pix),
        .pbyte             (pbyte),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        pbyte.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (!rst_n || (pix.valid && pix.ready) || (pbyte.valid && pbyte.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(126, 130));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_item(logic [VALUE_W-1:0] value, logic [COL_W-1:0] col,
                             logic [CH_W-1:0] ch, logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid       <= 1'b1;
        pix.pixel_value <= value;
        pix.column      <= col;
        pix.channel     <= ch;
        pix.row_end     <= last;
        @(posedge clk);
        while (pix.ready !== 1'b1)
            @(posedge clk);
        if (ch != CH_UNUSED)
            items_sent++;
        steady <= (items_sent >= STEADY_FROM && items_sent < STEADY_TO);
    endtask

    // one scanline, either a single channel or red, green, blue per column
    task automatic send_row(bit interleave);
        int base;
        int len;
        int solo;
        case ($urandom_range(0, 4))
            0:       base = 0;
            1:       base = 8;
            2:       base = MAX_COLUMNS - 8;
            3:       base = 1000;
            default: base = $urandom_range(0, 2047 - MAX_ROW_LEN);
        endcase
        len  = $urandom_range(1, MAX_ROW_LEN);
        solo = $urandom_range(0, NUM_CHANNELS - 1);
        for (int c = 0; c < len; c++)
        begin
            for (int k = 0; k < NUM_CHANNELS; k++)
            begin
                if (interleave || k == solo)
                    send_item(random_value(), COL_W'(base + c), CH_W'(k), c == len - 1);
            end
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        steady          <= 1'b0;
        pix.valid       <= 1'b0;
        pix.pixel_value <= '0;
        pix.column      <= '0;
        pix.channel     <= CH_RED;
        pix.row_end     <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        send_item(8'd255, 11'd0, CH_RED, 1'b0);
        send_item(8'd0, 11'd1, CH_GREEN, 1'b0);
        send_item(8'd128, 11'd2, CH_BLUE, 1'b0);
        send_item(8'd129, 11'd3, CH_RED, 1'b1);
        send_item(8'd200, 11'd4, CH_UNUSED, 1'b1);
        send_item(8'd77, 11'd5, CH_GREEN, 1'b0);
        send_item(8'd255, 11'd6, CH_GREEN, 1'b0);
        send_item(8'd255, 11'd7, CH_GREEN, 1'b0);
        send_item(8'd1, 11'd15, CH_BLUE, 1'b1);
        send_item(8'd255, 11'd1439, CH_BLUE, 1'b1);
        send_item(8'd255, 11'd1440, CH_RED, 1'b0);
        send_item(8'd0, 11'd2047, CH_GREEN, 1'b1);
        send_item(8'd170, 11'd1024, CH_RED, 1'b0);
        send_item(8'd85, 11'd1023, CH_BLUE, 1'b1);
        send_item(8'd128, 11'd0, CH_RED, 1'b0);
        send_item(8'd255, 11'd1439, CH_BLUE, 1'b0);
        send_item(8'd3, 11'd1440, CH_UNUSED, 1'b0);
        send_item(8'd0, 11'd0, CH_RED, 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    repeat ($urandom_range(1, 4))
                        send_item(random_value(), COL_W'($urandom_range(0, 2047)),
                                  CH_W'($urandom_range(0, 3)), $urandom_range(0, 7) == 0);
                2, 3, 4, 5:
                    send_row(1'b0);
                default:
                    send_row(1'b1);
            endcase
        end
        pix.valid <= 1'b0;

        do
            @(posedge clk);
        while (bytes_outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && bytes_outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
